>>> hw/rtl/dop_pkg.sv
// ----------------------------------------------------------------------------
// dop_pkg
// types and constants shared by the dhcp option parser and its checker
// ----------------------------------------------------------------------------
package dop_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_MASK     = 8'd1;
  localparam logic [7:0] OPT_ROUTER   = 8'd3;
  localparam logic [7:0] OPT_DNS      = 8'd6;
  localparam logic [7:0] OPT_TTL      = 8'd23;
  localparam logic [7:0] OPT_ARP      = 8'd35;
  localparam logic [7:0] OPT_LEASE    = 8'd51;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER   = 8'd54;
  localparam logic [7:0] OPT_RENEW    = 8'd58;
  localparam logic [7:0] OPT_REBIND   = 8'd59;
  localparam logic [7:0] OPT_END      = 8'd255;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  message_type;
    logic [31:0] subnet_mask;
    logic [31:0] router_addr;
    logic [31:0] server_id;
    logic [31:0] dns_addr;
    logic [31:0] lease_secs;
    logic [31:0] renew_secs;
    logic [31:0] rebind_secs;
    logic [7:0]  ip_ttl;
    logic [31:0] arp_cache_secs;
  } out_item_t;

endpackage

>>> hw/rtl/dhcp_option_parser.sv
// ----------------------------------------------------------------------------
// dhcp_option_parser
// walks the dhcp options area one byte per transaction and reports the
// captured option values when the area ends or an option length is bad
//
//   channel  direction  payload            handshake
//   in_      input      dop_pkg::in_item_t  in_valid / in_stall
//   out_     output     dop_pkg::out_item_t out_valid / out_stall
//
// one byte per cycle sustained unless a stalled result holds; a byte is
// captured in the input register, then the option walk and the lease split
// (a 35-bit subtract) update the state and result register in the same cycle
// synchronous active-low reset clears the walk and all captured values
// out_stall holds the result register; the input register then holds and
// in_stall rises, so at most two bytes are in flight
// ----------------------------------------------------------------------------
module dhcp_option_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dop_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dop_pkg::out_item_t  out_item
);

  typedef enum logic [2:0] {
    PH_CODE,
    PH_LEN,
    PH_VALUE,
    PH_SKIP,
    PH_DRAIN
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [2:0]  got_r, got_nxt;
  logic [7:0]  msg_r, msg_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [31:0] router_r, router_nxt;
  logic [31:0] server_r, server_nxt;
  logic [31:0] dns_r, dns_nxt;
  logic [31:0] lease_r, lease_nxt;
  logic [31:0] renew_r, renew_nxt;
  logic [31:0] rebind_r, rebind_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [31:0] arp_r, arp_nxt;

  dop_pkg::in_item_t  s1_r;
  logic               s1_valid_r;
  dop_pkg::out_item_t out_r, res;
  logic               out_valid_r;
  logic               emit;
  logic               adv;
  logic               accept;
  logic [34:0]        seven_v;

  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    logic [7:0] b;
    logic [2:0] size;
    logic       drain;
    b          = s1_r.data_byte;
    drain      = 1'b0;
    emit       = 1'b0;
    seven_v    = '0;
    res        = '0;
    res.status = dop_pkg::ST_OK;
    phase_nxt  = phase_r;
    code_nxt   = code_r;
    left_nxt   = left_r;
    shift_nxt  = shift_r;
    got_nxt    = got_r;
    msg_nxt    = msg_r;
    mask_nxt   = mask_r;
    router_nxt = router_r;
    server_nxt = server_r;
    dns_nxt    = dns_r;
    lease_nxt  = lease_r;
    renew_nxt  = renew_r;
    rebind_nxt = rebind_r;
    ttl_nxt    = ttl_r;
    arp_nxt    = arp_r;

    if (s1_r.restart) begin
      phase_nxt  = PH_CODE;
      code_nxt   = '0;
      left_nxt   = '0;
      shift_nxt  = '0;
      got_nxt    = '0;
      msg_nxt    = '0;
      mask_nxt   = '0;
      router_nxt = '0;
      server_nxt = '0;
      dns_nxt    = '0;
      lease_nxt  = '0;
      renew_nxt  = '0;
      rebind_nxt = '0;
      ttl_nxt    = '0;
      arp_nxt    = '0;
    end

    size = ((code_nxt == dop_pkg::OPT_MSG_TYPE) || (code_nxt == dop_pkg::OPT_TTL)) ?
           3'd1 : 3'd4;

    unique case (phase_nxt)
      PH_CODE: begin
        if (b == dop_pkg::OPT_END) begin
          emit = 1'b1;
        end else if (b != dop_pkg::OPT_PAD) begin
          code_nxt  = b;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        left_nxt = b;
        case (code_nxt) inside
          dop_pkg::OPT_MSG_TYPE: begin
            if (b != 8'd1) begin
              emit       = 1'b1;
              res.status = dop_pkg::ST_BAD;
            end
          end
          dop_pkg::OPT_MASK, dop_pkg::OPT_RENEW, dop_pkg::OPT_REBIND,
          dop_pkg::OPT_ARP: begin
            if (b != 8'd4) begin
              emit       = 1'b1;
              res.status = dop_pkg::ST_BAD;
            end
          end
          dop_pkg::OPT_ROUTER, dop_pkg::OPT_SERVER, dop_pkg::OPT_DNS: begin
            if (b < 8'd4) begin
              emit       = 1'b1;
              res.status = dop_pkg::ST_BAD;
            end
          end
          default: begin
          end
        endcase
        if (!emit) begin
          if (((code_nxt == dop_pkg::OPT_LEASE) && (b != 8'd4)) ||
              ((code_nxt == dop_pkg::OPT_TTL) && (b != 8'd1)) ||
              !((code_nxt == dop_pkg::OPT_MSG_TYPE) || (code_nxt == dop_pkg::OPT_MASK) ||
                (code_nxt == dop_pkg::OPT_RENEW) || (code_nxt == dop_pkg::OPT_REBIND) ||
                (code_nxt == dop_pkg::OPT_ARP) || (code_nxt == dop_pkg::OPT_ROUTER) ||
                (code_nxt == dop_pkg::OPT_SERVER) || (code_nxt == dop_pkg::OPT_DNS) ||
                (code_nxt == dop_pkg::OPT_LEASE) || (code_nxt == dop_pkg::OPT_TTL))) begin
            phase_nxt = (b == 8'd0) ? PH_CODE : PH_SKIP;
          end else begin
            got_nxt   = '0;
            shift_nxt = '0;
            phase_nxt = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        shift_nxt = {shift_nxt[23:0], b};
        left_nxt  = left_nxt - 8'd1;
        got_nxt   = got_nxt + 3'd1;
        if (got_nxt >= size) begin
          case (code_nxt)
            dop_pkg::OPT_MSG_TYPE: msg_nxt    = shift_nxt[7:0];
            dop_pkg::OPT_MASK:     mask_nxt   = shift_nxt;
            dop_pkg::OPT_ROUTER:   router_nxt = shift_nxt;
            dop_pkg::OPT_SERVER:   server_nxt = shift_nxt;
            dop_pkg::OPT_DNS:      dns_nxt    = shift_nxt;
            dop_pkg::OPT_LEASE: begin
              lease_nxt = shift_nxt;
              seven_v   = {shift_nxt, 3'b000} - {3'b000, shift_nxt};
              if (rebind_nxt == 32'd0) rebind_nxt = seven_v[34:3];
              if (renew_nxt == 32'd0) renew_nxt = {1'b0, shift_nxt[31:1]};
            end
            dop_pkg::OPT_RENEW:    renew_nxt  = shift_nxt;
            dop_pkg::OPT_REBIND:   rebind_nxt = shift_nxt;
            dop_pkg::OPT_TTL:      ttl_nxt    = shift_nxt[7:0];
            dop_pkg::OPT_ARP:      arp_nxt    = shift_nxt;
            default: begin
            end
          endcase
          phase_nxt = (left_nxt == 8'd0) ? PH_CODE : PH_SKIP;
        end
      end
      PH_SKIP: begin
        left_nxt = left_nxt - 8'd1;
        if (left_nxt == 8'd0) phase_nxt = PH_CODE;
      end
      PH_DRAIN: begin
        drain = 1'b1;
        if (s1_r.last_byte) phase_nxt = PH_CODE;
      end
      default: begin
        phase_nxt = PH_CODE;
      end
    endcase

    if (!drain) begin
      if (emit) begin
        phase_nxt = s1_r.last_byte ? PH_CODE : PH_DRAIN;
      end else if (s1_r.last_byte) begin
        emit       = 1'b1;
        res.status = dop_pkg::ST_SHORT;
        phase_nxt  = PH_CODE;
      end
    end

    res.message_type   = msg_nxt;
    res.subnet_mask    = mask_nxt;
    res.router_addr    = router_nxt;
    res.server_id      = server_nxt;
    res.dns_addr       = dns_nxt;
    res.lease_secs     = lease_nxt;
    res.renew_secs     = renew_nxt;
    res.rebind_secs    = rebind_nxt;
    res.ip_ttl         = ttl_nxt;
    res.arp_cache_secs = arp_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_item;
    end
    if (adv && emit) begin
      out_r <= res;
    end
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_CODE;
      code_r      <= '0;
      left_r      <= '0;
      shift_r     <= '0;
      got_r       <= '0;
      msg_r       <= '0;
      mask_r      <= '0;
      router_r    <= '0;
      server_r    <= '0;
      dns_r       <= '0;
      lease_r     <= '0;
      renew_r     <= '0;
      rebind_r    <= '0;
      ttl_r       <= '0;
      arp_r       <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (adv) begin
        phase_r  <= phase_nxt;
        code_r   <= code_nxt;
        left_r   <= left_nxt;
        shift_r  <= shift_nxt;
        got_r    <= got_nxt;
        msg_r    <= msg_nxt;
        mask_r   <= mask_nxt;
        router_r <= router_nxt;
        server_r <= server_nxt;
        dns_r    <= dns_nxt;
        lease_r  <= lease_nxt;
        renew_r  <= renew_nxt;
        rebind_r <= rebind_nxt;
        ttl_r    <= ttl_nxt;
        arp_r    <= arp_nxt;
      end
    end
  end

endmodule

>>> hw/rtl/dop_checker.sv
// ----------------------------------------------------------------------------
// dop_checker
// port-level checks for the dhcp option parser, bound into each parser instance
// ----------------------------------------------------------------------------
module dop_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input dop_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input dop_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == dop_pkg::ST_OK) ||
                  (out_item.status == dop_pkg::ST_BAD) ||
                  (out_item.status == dop_pkg::ST_SHORT))
    else $error("undefined status");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall && out_valid)
    else $error("input stalled without output backpressure");

endmodule

bind dhcp_option_parser dop_checker u_dop_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
